// ===== hdl/nearest_neighbor_image_downscaler_core_macros.svh =====
// ----------------------------------------------------------------------------
// Nearest-neighbour downscaler assertion macros
// Shared property forms for the core's concurrent checks, clocked on i_clk
// and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_IMAGE_DOWNSCALER_CORE_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_DOWNSCALER_CORE_MACROS_SVH

// same-cycle implication
`define NND_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NND_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/nnd_pkg.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbour downscaler package
// Shared widths, defaults, register indexes, the queued item type and the
// size clamp.
// ----------------------------------------------------------------------------
package nnd_pkg;

    localparam int unsigned PIX_W          = 16;
    localparam int unsigned CFG_W          = 9;
    localparam int unsigned DEF_SRC_WIDTH  = 480;
    localparam int unsigned DEF_SRC_HEIGHT = 320;
    localparam logic [CFG_W-1:0] DEF_DEST_WIDTH  = 9'd480;
    localparam logic [CFG_W-1:0] DEF_DEST_HEIGHT = 9'd320;
    localparam int unsigned QUEUE_DEPTH    = 2;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IDX_DEST_WIDTH  = 1'b0;
    localparam t_cfg_idx CFG_IDX_DEST_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [CFG_W-1:0] dest_x;
        logic [CFG_W-1:0] dest_y;
        logic             last;
    } t_nnd_item;

    function automatic logic [CFG_W-1:0] nnd_clamp(input logic [CFG_W-1:0] v,
                                                   input int unsigned limit);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (32'(v) > limit) begin
            res = limit[CFG_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/nearest_neighbor_image_downscaler_core.sv =====
// A picked pixel is written into the result queue when it is accepted; the queue head drives the output.
// Throughput: one source pixel per cycle; the input stalls while the dividers run or two items are queued.
// After reset and after every register write the step dividers run with the input stalled.
// Reset: synchronous, active low; clears position, loads 480 x 320 destination size.
// ----------------------------------------------------------------------------
// Nearest-neighbour image downscaler core
// Passes on the source pixels that nearest-neighbour sampling picks, tagged
// with destination coordinates and a frame-end mark.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_downscaler_core #(
    parameter int unsigned SRC_WIDTH  = nnd_pkg::DEF_SRC_WIDTH,
    parameter int unsigned SRC_HEIGHT = nnd_pkg::DEF_SRC_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [nnd_pkg::PIX_W-1:0]   i_pixel_in,
    input  logic                        i_frame_start,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [nnd_pkg::PIX_W-1:0]   o_pixel_out,
    output logic [nnd_pkg::CFG_W-1:0]   o_dest_x,
    output logic [nnd_pkg::CFG_W-1:0]   o_dest_y,
    output logic                        o_frame_last,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  nnd_pkg::t_cfg_idx           i_cfg_index,
    input  logic [nnd_pkg::CFG_W-1:0]   i_cfg_data
);
    import nnd_pkg::*;

    localparam int unsigned CW = $clog2(SRC_WIDTH + 1);
    localparam int unsigned RW = $clog2(SRC_HEIGHT + 1);

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic             r_div_start;

    logic             col_busy, row_busy;
    logic [CW-1:0]    col_quot;
    logic [RW-1:0]    row_quot;
    logic [CFG_W-1:0] col_rem, row_rem;

    logic             accept;
    logic             cfg_wr;
    logic             q_full;
    logic             push;
    t_nnd_item        push_item;
    t_nnd_item        head;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_stall     = r_div_start || col_busy || row_busy || q_full;
    assign accept      = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= nnd_clamp(DEF_DEST_WIDTH, SRC_WIDTH);
            r_height    <= nnd_clamp(DEF_DEST_HEIGHT, SRC_HEIGHT);
            r_div_start <= 1'b1;
        end else begin
            r_div_start <= cfg_wr;
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_IDX_DEST_WIDTH:  r_width  <= nnd_clamp(i_cfg_data, SRC_WIDTH);
                    CFG_IDX_DEST_HEIGHT: r_height <= nnd_clamp(i_cfg_data, SRC_HEIGHT);
                    default: ;
                endcase
            end
        end
    end

    nnd_div #(.DIVIDEND(SRC_WIDTH)) u_col_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_divisor (r_width),
        .o_busy    (col_busy),
        .o_quot    (col_quot),
        .o_rem     (col_rem)
    );

    nnd_div #(.DIVIDEND(SRC_HEIGHT)) u_row_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_divisor (r_height),
        .o_busy    (row_busy),
        .o_quot    (row_quot),
        .o_rem     (row_rem)
    );

    nnd_front #(
        .SRC_WIDTH  (SRC_WIDTH),
        .SRC_HEIGHT (SRC_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_pixel       (i_pixel_in),
        .i_frame_start (i_frame_start),
        .i_width       (r_width),
        .i_height      (r_height),
        .i_col_quot    (col_quot),
        .i_col_rem     (col_rem),
        .i_row_quot    (row_quot),
        .i_row_rem     (row_rem),
        .o_push        (push),
        .o_item        (push_item)
    );

    nnd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (head)
    );

    assign o_pixel_out  = head.pixel;
    assign o_dest_x     = head.dest_x;
    assign o_dest_y     = head.dest_y;
    assign o_frame_last = head.last;

endmodule

// ===== hdl/nnd_div.sv =====
// ----------------------------------------------------------------------------
// Step divider
// Restoring division of a fixed source dimension by a destination size, one
// quotient bit per cycle; gives the per-pick step and its remainder.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_image_downscaler_core_macros.svh"

module nnd_div #(
    parameter int unsigned DIVIDEND = 480
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [nnd_pkg::CFG_W-1:0]           i_divisor,
    output logic                                o_busy,
    output logic [$clog2(DIVIDEND+1)-1:0]       o_quot,
    output logic [nnd_pkg::CFG_W-1:0]           o_rem
);
    import nnd_pkg::*;

    localparam int unsigned QW    = $clog2(DIVIDEND + 1);
    localparam int unsigned CNT_W = $clog2(QW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [QW-1:0]    r_quot;
    logic [CFG_W-1:0] r_rem;
    logic [CFG_W-1:0] r_dvs;

    logic [CFG_W:0]   trial;
    logic [CFG_W:0]   diff;
    logic             fits;
    logic [QW-1:0]    n_quot;
    logic [CFG_W-1:0] n_rem;

    always_comb begin
        trial  = {r_rem, r_quot[QW-1]};
        diff   = trial - {1'b0, r_dvs};
        fits   = trial >= {1'b0, r_dvs};
        n_rem  = fits ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
        n_quot = QW'({r_quot, fits});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= QW'(DIVIDEND);
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    `NND_ASSERT_NEXT(a_div_start_busy, i_start, r_busy && r_cnt == CNT_W'(QW), "divider did not start")

endmodule

// ===== hdl/nnd_front.sv =====
// ----------------------------------------------------------------------------
// Downscaler front end
// Tracks source and destination position, decides per source pixel whether
// it is picked, and advances the picked column and row by step and remainder.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_image_downscaler_core_macros.svh"

module nnd_front #(
    parameter int unsigned SRC_WIDTH  = nnd_pkg::DEF_SRC_WIDTH,
    parameter int unsigned SRC_HEIGHT = nnd_pkg::DEF_SRC_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [nnd_pkg::PIX_W-1:0]           i_pixel,
    input  logic                                i_frame_start,
    input  logic [nnd_pkg::CFG_W-1:0]           i_width,
    input  logic [nnd_pkg::CFG_W-1:0]           i_height,
    input  logic [$clog2(SRC_WIDTH+1)-1:0]      i_col_quot,
    input  logic [nnd_pkg::CFG_W-1:0]           i_col_rem,
    input  logic [$clog2(SRC_HEIGHT+1)-1:0]     i_row_quot,
    input  logic [nnd_pkg::CFG_W-1:0]           i_row_rem,
    output logic                                o_push,
    output nnd_pkg::t_nnd_item                  o_item
);
    import nnd_pkg::*;

    localparam int unsigned CW = $clog2(SRC_WIDTH + 1);
    localparam int unsigned RW = $clog2(SRC_HEIGHT + 1);

    logic [CW-1:0]    r_scol, n_scol, e_scol;
    logic [RW-1:0]    r_srow, n_srow, e_srow;
    logic [CFG_W-1:0] r_dcol, n_dcol, e_dcol;
    logic [CFG_W-1:0] r_drow, n_drow, e_drow;
    logic [CW-1:0]    r_pcol, n_pcol, e_pcol;
    logic [RW-1:0]    r_prow, n_prow, e_prow;
    logic [CFG_W-1:0] r_crem, n_crem, e_crem;
    logic [CFG_W-1:0] r_rrem, n_rrem, e_rrem;

    logic             row_act;
    logic             emit;
    logic [CFG_W:0]   c_sum, r_sum;
    logic             c_carry, r_carry;
    logic [CW:0]      pc_sum;
    logic [RW:0]      pr_sum;

    always_comb begin
        e_scol = i_frame_start ? '0 : r_scol;
        e_srow = i_frame_start ? '0 : r_srow;
        e_dcol = i_frame_start ? '0 : r_dcol;
        e_drow = i_frame_start ? '0 : r_drow;
        e_pcol = i_frame_start ? '0 : r_pcol;
        e_prow = i_frame_start ? '0 : r_prow;
        e_crem = i_frame_start ? '0 : r_crem;
        e_rrem = i_frame_start ? '0 : r_rrem;

        row_act = (e_srow == e_prow) && (e_drow < i_height);
        emit    = row_act && (e_dcol < i_width) && (e_scol == e_pcol);

        c_sum   = {1'b0, e_crem} + {1'b0, i_col_rem};
        c_carry = c_sum >= {1'b0, i_width};
        pc_sum  = (CW+1)'(e_pcol) + (CW+1)'(i_col_quot) + (CW+1)'(c_carry);
        r_sum   = {1'b0, e_rrem} + {1'b0, i_row_rem};
        r_carry = r_sum >= {1'b0, i_height};
        pr_sum  = (RW+1)'(e_prow) + (RW+1)'(i_row_quot) + (RW+1)'(r_carry);

        n_scol = e_scol;
        n_srow = e_srow;
        n_dcol = e_dcol;
        n_drow = e_drow;
        n_pcol = e_pcol;
        n_prow = e_prow;
        n_crem = e_crem;
        n_rrem = e_rrem;

        if (emit) begin
            n_dcol = e_dcol + CFG_W'(1);
            // saturate: any position past the row never matches again
            n_pcol = (pc_sum > (CW+1)'(SRC_WIDTH)) ? CW'(SRC_WIDTH) : pc_sum[CW-1:0];
            n_crem = c_carry ? CFG_W'(c_sum - {1'b0, i_width}) : c_sum[CFG_W-1:0];
        end

        if (e_scol == CW'(SRC_WIDTH - 1)) begin
            n_scol = '0;
            if (row_act) begin
                n_drow = e_drow + CFG_W'(1);
                n_dcol = '0;
                n_pcol = '0;
                n_crem = '0;
                n_prow = (pr_sum > (RW+1)'(SRC_HEIGHT)) ? RW'(SRC_HEIGHT)
                                                        : pr_sum[RW-1:0];
                n_rrem = r_carry ? CFG_W'(r_sum - {1'b0, i_height})
                                 : r_sum[CFG_W-1:0];
            end
            if (e_srow == RW'(SRC_HEIGHT - 1)) begin
                n_srow = '0;
                n_drow = '0;
                n_dcol = '0;
                n_pcol = '0;
                n_prow = '0;
                n_crem = '0;
                n_rrem = '0;
            end else begin
                n_srow = e_srow + RW'(1);
            end
        end else begin
            n_scol = e_scol + CW'(1);
        end

        o_push        = i_accept && emit;
        o_item.pixel  = i_pixel;
        o_item.dest_x = e_dcol;
        o_item.dest_y = e_drow;
        o_item.last   = (e_dcol == i_width - CFG_W'(1)) && (e_drow == i_height - CFG_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol <= '0;
            r_srow <= '0;
            r_dcol <= '0;
            r_drow <= '0;
            r_pcol <= '0;
            r_prow <= '0;
            r_crem <= '0;
            r_rrem <= '0;
        end else if (i_accept) begin
            r_scol <= n_scol;
            r_srow <= n_srow;
            r_dcol <= n_dcol;
            r_drow <= n_drow;
            r_pcol <= n_pcol;
            r_prow <= n_prow;
            r_crem <= n_crem;
            r_rrem <= n_rrem;
        end
    end

    `NND_ASSERT_IMPL(a_front_pos_range, 1'b1, r_scol < CW'(SRC_WIDTH) && r_srow < RW'(SRC_HEIGHT), "source position out of frame")

endmodule

// ===== hdl/nnd_queue.sv =====
// ----------------------------------------------------------------------------
// Downscaler result queue
// Short queue between the front end and the output channel; its head is the
// registered output item.
// ----------------------------------------------------------------------------
`include "nearest_neighbor_image_downscaler_core_macros.svh"

module nnd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nnd_pkg::t_nnd_item i_item,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output nnd_pkg::t_nnd_item o_item
);
    import nnd_pkg::*;

    localparam int unsigned PW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_nnd_item        r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             pop;

    assign pop     = o_valid && !i_stall;
    assign o_valid = r_cnt != '0;
    assign o_full  = r_cnt == CNT_W'(QUEUE_DEPTH);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `NND_ASSERT_IMPL(a_queue_no_overrun, i_push, !o_full, "push into full queue")
    `NND_ASSERT_NEXT(a_queue_fill, i_push && !pop, r_cnt == $past(r_cnt) + CNT_W'(1), "fill count lost a push")

endmodule

// ===== tb/tb_nearest_neighbor_image_downscaler_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nearest-neighbour downscaler core testbench
// Streams RGB565 source pixels through the core at a range of destination
// sizes and checks every picked pixel, its destination coordinates and the
// frame-end mark against a behavioural pick tracker. Covers size clamping,
// a full-rate run across a row end, sparse sizes, size changes part way
// through a frame, and random idling on both sides of the core.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_image_downscaler_core;
    import nnd_pkg::*;

    localparam int unsigned SRC_W          = DEF_SRC_WIDTH;
    localparam int unsigned SRC_H          = DEF_SRC_HEIGHT;
    localparam int unsigned IDLE_PCT       = 37;
    localparam int unsigned QUIET_CYCLES   = 4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASES         = 8;
    localparam int unsigned STEADY_PIXELS  = 490;
    localparam int unsigned SPARSE_PIXELS  = 100;

    class nn_pick_tracker;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        logic [CFG_W-1:0] src_col;
        logic [CFG_W-1:0] src_row;
        logic [CFG_W-1:0] dst_col;
        logic [CFG_W-1:0] dst_row;
        logic [10:0]      pick_col;
        logic [10:0]      pick_row;
        logic [10:0]      col_rem;
        logic [10:0]      row_rem;
        t_nnd_item        picked_q[$];
        int unsigned      mismatches;

        function new();
            width_reg  = DEF_DEST_WIDTH;
            height_reg = DEF_DEST_HEIGHT;
            mismatches = 0;
            restart_frame();
        endfunction

        function void restart_frame();
            src_col  = '0;
            src_row  = '0;
            dst_col  = '0;
            dst_row  = '0;
            pick_col = '0;
            pick_row = '0;
            col_rem  = '0;
            row_rem  = '0;
        endfunction

        function int unsigned clamp_size(input logic [CFG_W-1:0] v, input int unsigned limit);
            if (v == '0) return 1;
            if (v > limit) return limit;
            return v;
        endfunction

        function void step_pick(inout logic [10:0] pos, inout logic [10:0] rem,
                                input int unsigned src, input int unsigned dst);
            logic [10:0] r;
            r   = rem + 11'(src % dst);
            pos = pos + 11'(src / dst);
            if (r >= dst) begin
                r   = r - 11'(dst);
                pos = pos + 11'd1;
            end
            rem = r;
        endfunction

        function void write_size(input t_cfg_idx idx, input logic [CFG_W-1:0] v);
            if (idx == CFG_IDX_DEST_WIDTH) begin
                width_reg = v;
            end else begin
                height_reg = v;
            end
        endfunction

        function void note_source(input logic [PIX_W-1:0] pix, input logic fs);
            int unsigned w;
            int unsigned h;
            logic        row_live;
            t_nnd_item   item;
            w = clamp_size(width_reg, SRC_W);
            h = clamp_size(height_reg, SRC_H);
            if (fs) restart_frame();
            row_live = (src_row == pick_row) && (dst_row < h);
            if (row_live && dst_col < w && src_col == pick_col) begin
                item.pixel  = pix;
                item.dest_x = dst_col;
                item.dest_y = dst_row;
                item.last   = (dst_col == w - 1) && (dst_row == h - 1);
                picked_q.push_back(item);
                dst_col = dst_col + 1'b1;
                step_pick(pick_col, col_rem, SRC_W, w);
            end
            if (src_col + 1 >= SRC_W) begin
                src_col = '0;
                if (row_live) begin
                    dst_row  = dst_row + 1'b1;
                    dst_col  = '0;
                    pick_col = '0;
                    col_rem  = '0;
                    step_pick(pick_row, row_rem, SRC_H, h);
                end
                if (src_row + 1 >= SRC_H) begin
                    restart_frame();
                end else begin
                    src_row = src_row + 1'b1;
                end
            end else begin
                src_col = src_col + 1'b1;
            end
        endfunction

        function void check_picked(input logic [PIX_W-1:0] pix, input logic [CFG_W-1:0] x,
                                   input logic [CFG_W-1:0] y, input logic fl);
            t_nnd_item exp_item;
            if (picked_q.size() == 0) begin
                $error("unexpected item: pixel_out %h dest_x %0d dest_y %0d frame_last %0d",
                       pix, x, y, fl);
                mismatches++;
                return;
            end
            exp_item = picked_q.pop_front();
            if (pix !== exp_item.pixel) begin
                $error("pixel_out: expected %h, actual %h", exp_item.pixel, pix);
                mismatches++;
            end
            if (x !== exp_item.dest_x) begin
                $error("dest_x: expected %0d, actual %0d", exp_item.dest_x, x);
                mismatches++;
            end
            if (y !== exp_item.dest_y) begin
                $error("dest_y: expected %0d, actual %0d", exp_item.dest_y, y);
                mismatches++;
            end
            if (fl !== exp_item.last) begin
                $error("frame_last: expected %0d, actual %0d", exp_item.last, fl);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return picked_q.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [PIX_W-1:0] i_pixel_in;
    logic             i_frame_start;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [PIX_W-1:0] o_pixel_out;
    logic [CFG_W-1:0] o_dest_x;
    logic [CFG_W-1:0] o_dest_y;
    logic             o_frame_last;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    t_cfg_idx         i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    bit               steady = 1'b0;
    int unsigned      idle_cycles = 0;
    nn_pick_tracker   picker = new();

    nearest_neighbor_image_downscaler_core #(
        .SRC_WIDTH  (SRC_W),
        .SRC_HEIGHT (SRC_H)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_in    (i_pixel_in),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_out   (o_pixel_out),
        .o_dest_x      (o_dest_x),
        .o_dest_y      (o_dest_y),
        .o_frame_last  (o_frame_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                picker.check_picked(o_pixel_out, o_dest_x, o_dest_y, o_frame_last);
            end
            if (i_valid && !o_stall) begin
                picker.note_source(i_pixel_in, i_frame_start);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                picker.write_size(i_cfg_index, i_cfg_data);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_source_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_in    <= pix;
        i_frame_start <= fs;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (picker.pending() != 0);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        hold_until_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic stream_frame(input int unsigned count);
        for (int unsigned j = 0; j < count; j++) begin
            send_source_pixel(PIX_W'($urandom_range(0, 65535)), j == 0);
        end
    endtask

    initial begin
        int unsigned      len;
        logic [CFG_W-1:0] w_set;
        logic [CFG_W-1:0] h_set;
        logic             fs;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pixel_in    = '0;
        i_frame_start = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_IDX_DEST_WIDTH;
        i_cfg_data    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size picks every source pixel
        send_source_pixel(16'hFFFF, 1'b1);
        send_source_pixel(16'h0000, 1'b0);
        send_source_pixel(16'hAAAA, 1'b0);
        send_source_pixel(16'h5555, 1'b0);

        // zero sizes count as one: the first pixel is also the frame end
        write_size_reg(CFG_IDX_DEST_WIDTH, 9'd0);
        write_size_reg(CFG_IDX_DEST_HEIGHT, 9'd0);
        send_source_pixel(16'h1234, 1'b1);
        send_source_pixel(16'hFFFF, 1'b0);
        send_source_pixel(16'h0000, 1'b0);

        // oversize registers clamp to the source
        write_size_reg(CFG_IDX_DEST_WIDTH, 9'h1FF);
        write_size_reg(CFG_IDX_DEST_HEIGHT, 9'h1FF);
        send_source_pixel(16'h0F0F, 1'b1);
        send_source_pixel(16'hF0F0, 1'b0);
        send_source_pixel(16'hFFFF, 1'b1);

        // full-size run across the first row end with no idling on either side
        write_size_reg(CFG_IDX_DEST_WIDTH, 9'd480);
        write_size_reg(CFG_IDX_DEST_HEIGHT, 9'd320);
        steady <= 1'b1;
        stream_frame(STEADY_PIXELS);
        steady <= 1'b0;

        // sparse sizes along the first row
        write_size_reg(CFG_IDX_DEST_WIDTH, 9'd7);
        write_size_reg(CFG_IDX_DEST_HEIGHT, 9'd13);
        stream_frame(SPARSE_PIXELS);

        // random phases; position carries across size changes
        for (int unsigned p = 0; p < PHASES; p++) begin
            case (p)
                0: begin w_set = 9'd480; h_set = 9'd320; end
                1: begin w_set = 9'd1;   h_set = 9'd1;   end
                2: begin w_set = 9'd480; h_set = 9'd1;   end
                3: begin w_set = 9'd3;   h_set = 9'd320; end
                default: begin
                    w_set = CFG_W'($urandom_range(0, 511));
                    h_set = CFG_W'($urandom_range(0, 511));
                end
            endcase
            write_size_reg(CFG_IDX_DEST_WIDTH, w_set);
            write_size_reg(CFG_IDX_DEST_HEIGHT, h_set);
            len = $urandom_range(50, 90);
            for (int unsigned k = 0; k < len; k++) begin
                fs = ($urandom_range(0, 399) == 0) || (k == 0 && $urandom_range(0, 1) == 1);
                send_source_pixel(PIX_W'($urandom_range(0, 65535)), fs);
                if ($urandom_range(0, 149) == 0) hold_until_drained();
            end
        end

        hold_until_drained();
        repeat (8) @(posedge i_clk);
        if (picker.mismatches == 0 && picker.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
